>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the pixel cleanup block, included by its top level.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is not checked while reset is high.
`define BRIP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("brip assertion failed");

// Clocked property that is checked in every cycle, reset included.
`define BRIP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("brip assertion failed");

`endif

>>> rtl/brip_pkg.sv
// Package of the pixel binarize and cleanup block: sizes, register codes and types.
// Used by the channel interfaces, the line store, the window cell and the top level.
package brip_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COORD_W    = 12;
   localparam int SIZE_W     = 13;
   localparam int PIX_W      = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(2);

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [PIX_W-1:0]   pix_type;

   localparam pix_type   THRESHOLD_RESET   = PIX_W'(128);
   localparam coord_type WIDTH_LAST_RESET  = COORD_W'(640 - 1);
   localparam coord_type HEIGHT_LAST_RESET = COORD_W'(480 - 1);

   // One column of the 3x3 window: the current row and the two rows above.
   typedef struct packed {
      logic cur;
      logic up1;
      logic up2;
   } column_type;

   // One entry of the line store: the rows two above and one above.
   typedef struct packed {
      logic older;
      logic previous;
   } line_word_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
      logic      cur;
      logic      row_end;
      logic      last_row;
   } item_type;

   // Turns a written frame size into its last index, saturated to [2, hi].
   function automatic coord_type size_to_last(size_type v, size_type hi);
      size_type s;
      begin
         if (v < SIZE_W'(2)) begin
            s = SIZE_W'(2);
         end else if (v > hi) begin
            s = hi;
         end else begin
            s = v;
         end
         return COORD_W'(s - SIZE_W'(1));
      end
   endfunction

endpackage

>>> rtl/brip_req_if.sv
// Pixel input channel: valid, ready and one RGB pixel.
// Depends on brip_pkg.
interface brip_req_if;
   logic             valid;
   logic             ready;
   brip_pkg::pix_type red;
   brip_pkg::pix_type green;
   brip_pkg::pix_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/brip_rsp_if.sv
// Result channel: valid, ready and one decided pixel with its coordinates.
// Depends on brip_pkg.
interface brip_rsp_if;
   logic                valid;
   logic                ready;
   brip_pkg::coord_type pixel_x;
   brip_pkg::coord_type pixel_y;
   logic                light;
   logic                last;

   modport source (output valid, output pixel_x, output pixel_y, output light,
                   output last, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input light,
                 input last, output ready);
endinterface

>>> rtl/binarize_remove_isolated_pixels_top.sv
// Top level of the pixel binarize and isolated pixel removal block.
// Depends on brip_pkg, brip_req_if, brip_rsp_if, brip_line_store, brip_window_cell.
//
// Pixels enter on req_chan in raster order, one item per RGB pixel. A pixel is
// light when its largest channel is above the threshold register. Results leave
// on rsp_chan as (pixel_x, pixel_y, light, last); last marks the final result
// caused by one input item. Row 0 gives no results, column 0 of later rows none,
// other pixels one, a row end two, and the last row twice as many, so the last
// pixel of a frame flushes it with four results.
// The csr port writes threshold, image width and image height; sizes saturate
// to 2..4096. Write them only while the block is idle.
// When the output stage is free, an accepted item waits in the input stage and then
// moves into the output stage, where its first result is valid and can be taken.
// Throughput is one item per cycle while each item gives at most one result and
// rsp_chan is ready; an item with more results holds the output stage until all
// of them are taken, which sets the rate on the last row and at row ends.
// The line store is read when an item is accepted and written when it moves
// into the window cells; its contents are not cleared at reset.
// Reset (synchronous) empties both stages, zeroes the window and the position
// and restores the register defaults. When rsp_chan stalls, one more item is
// taken into the input stage and then req_chan.ready drops.
`include "assert_macros.svh"

module binarize_remove_isolated_pixels_top (
   input  logic                                 clock,
   input  logic                                 reset,
   brip_req_if.sink                             req_chan,
   brip_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [brip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [brip_pkg::SIZE_W-1:0]          csr_write_data
);

   brip_pkg::pix_type       threshold_ff;
   brip_pkg::coord_type     width_last_ff;
   brip_pkg::coord_type     height_last_ff;

   brip_pkg::coord_type     col_ff, col_in;
   brip_pkg::coord_type     row_ff, row_in;
   logic                    req_fire;
   logic                    col_wrap;
   brip_pkg::size_type      row_step;
   brip_pkg::coord_type     pix_col;
   brip_pkg::coord_type     pix_row;
   brip_pkg::pix_type       max_rg;
   brip_pkg::pix_type       max_rgb;
   brip_pkg::item_type      new_item;

   logic                    a_valid_ff, a_valid_in;
   brip_pkg::item_type      a_item_ff;
   logic                    a_adv;
   brip_pkg::line_word_type line_rd;
   brip_pkg::line_word_type line_wr;

   logic [3:0]              b_mask_ff, b_mask_in;
   logic [3:0]              load_mask;
   brip_pkg::coord_type     b_col_ff;
   brip_pkg::coord_type     b_row_ff;
   logic                    b_single;
   logic                    rsp_fire;
   logic                    has_above;
   logic                    has_left;
   brip_pkg::column_type    new_col;
   brip_pkg::column_type    win_col0, win_col1, win_col2;
   logic                    interior;
   logic                    others_dark;
   logic                    center_light;
   brip_pkg::coord_type     x_prev;
   brip_pkg::coord_type     y_prev;

   // Configuration registers; the sizes are kept as saturated last indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= brip_pkg::THRESHOLD_RESET;
         width_last_ff  <= brip_pkg::WIDTH_LAST_RESET;
         height_last_ff <= brip_pkg::HEIGHT_LAST_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            brip_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_write_data[brip_pkg::PIX_W-1:0];
            end
            brip_pkg::CSR_IMAGE_WIDTH: begin
               width_last_ff <= brip_pkg::size_to_last(csr_write_data,
                                   brip_pkg::SIZE_W'(brip_pkg::MAX_WIDTH));
            end
            brip_pkg::CSR_IMAGE_HEIGHT: begin
               height_last_ff <= brip_pkg::size_to_last(csr_write_data,
                                    brip_pkg::SIZE_W'(brip_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   // Position and binarization of the incoming item.
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      col_wrap = col_ff > width_last_ff;
      row_step = {1'b0, row_ff} + brip_pkg::SIZE_W'(col_wrap);
      pix_col  = col_wrap ? '0 : col_ff;
      pix_row  = (row_step > {1'b0, height_last_ff}) ? '0
                                                     : row_step[brip_pkg::COORD_W-1:0];
      max_rg   = (req_chan.red > req_chan.green) ? req_chan.red : req_chan.green;
      max_rgb  = (max_rg > req_chan.blue) ? max_rg : req_chan.blue;

      new_item.col      = pix_col;
      new_item.row      = pix_row;
      new_item.cur      = max_rgb > threshold_ff;
      new_item.row_end  = pix_col == width_last_ff;
      new_item.last_row = pix_row == height_last_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (new_item.row_end) begin
            col_in = '0;
            row_in = new_item.last_row ? '0 : pix_row + brip_pkg::COORD_W'(1);
         end else begin
            col_in = pix_col + brip_pkg::COORD_W'(1);
            row_in = pix_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input stage: holds one item while its line store word is read.
   always_comb begin
      b_single   = (b_mask_ff != '0) && ((b_mask_ff & (b_mask_ff - 4'd1)) == '0);
      a_adv      = a_valid_ff && ((b_mask_ff == '0) || (rsp_chan.ready && b_single));
      a_valid_in = req_fire ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
   end

   assign req_chan.ready = !a_valid_ff || a_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff <= new_item;
      end
   end

   always_comb begin
      line_wr.older    = line_rd.previous;
      line_wr.previous = a_item_ff.cur;
      new_col.cur      = a_item_ff.cur;
      new_col.up1      = line_rd.previous;
      new_col.up2      = line_rd.older;
   end

   brip_line_store u_line_store (
      .clock        (clock),
      .write_enable (a_adv),
      .write_addr   (a_item_ff.col),
      .write_data   (line_wr),
      .read_enable  (req_fire),
      .read_addr    (pix_col),
      .read_data    (line_rd)
   );

   // Window: column c in cell 2, c-1 in cell 1, c-2 in cell 0.
   brip_window_cell u_cell2 (
      .clock   (clock),
      .reset   (reset),
      .shift   (a_adv),
      .col_in  (new_col),
      .col_out (win_col2)
   );

   brip_window_cell u_cell1 (
      .clock   (clock),
      .reset   (reset),
      .shift   (a_adv),
      .col_in  (win_col2),
      .col_out (win_col1)
   );

   brip_window_cell u_cell0 (
      .clock   (clock),
      .reset   (reset),
      .shift   (a_adv),
      .col_in  (win_col1),
      .col_out (win_col0)
   );

   // Output stage: one mask bit per pending result, sent lowest bit first.
   always_comb begin
      has_above    = a_item_ff.row != '0;
      has_left     = a_item_ff.col != '0;
      load_mask[0] = has_above && has_left;
      load_mask[1] = has_above && a_item_ff.row_end;
      load_mask[2] = has_above && a_item_ff.last_row && has_left;
      load_mask[3] = has_above && a_item_ff.last_row && a_item_ff.row_end;

      rsp_fire = rsp_chan.valid && rsp_chan.ready;
      if (a_adv) begin
         b_mask_in = load_mask;
      end else if (rsp_fire) begin
         b_mask_in = b_mask_ff & (b_mask_ff - 4'd1);
      end else begin
         b_mask_in = b_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_mask_ff <= '0;
      end else begin
         b_mask_ff <= b_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_col_ff <= a_item_ff.col;
         b_row_ff <= a_item_ff.row;
      end
   end

   always_comb begin
      interior     = (|b_col_ff[brip_pkg::COORD_W-1:1]) && (|b_row_ff[brip_pkg::COORD_W-1:1]);
      others_dark  = (win_col0 == '0) && !win_col1.up2 && !win_col1.cur && (win_col2 == '0);
      center_light = win_col1.up1 && !(interior && others_dark);
      x_prev       = b_col_ff - brip_pkg::COORD_W'(1);
      y_prev       = b_row_ff - brip_pkg::COORD_W'(1);

      rsp_chan.valid = b_mask_ff != '0;
      rsp_chan.last  = b_single;
      if (b_mask_ff[0]) begin
         rsp_chan.pixel_x = x_prev;
         rsp_chan.pixel_y = y_prev;
         rsp_chan.light   = center_light;
      end else if (b_mask_ff[1]) begin
         rsp_chan.pixel_x = b_col_ff;
         rsp_chan.pixel_y = y_prev;
         rsp_chan.light   = win_col2.up1;
      end else if (b_mask_ff[2]) begin
         rsp_chan.pixel_x = x_prev;
         rsp_chan.pixel_y = b_row_ff;
         rsp_chan.light   = win_col1.cur;
      end else begin
         rsp_chan.pixel_x = b_col_ff;
         rsp_chan.pixel_y = b_row_ff;
         rsp_chan.light   = win_col2.cur;
      end
   end

   `BRIP_ASSERT(a_more_results, clock, reset, rsp_fire && !rsp_chan.last |=> rsp_chan.valid)
   `BRIP_ASSERT(a_drained, clock, reset, rsp_fire && rsp_chan.last && !a_valid_ff |=> !rsp_chan.valid)
   `BRIP_ASSERT(a_row0_silent, clock, reset, a_adv && a_item_ff.row == '0 |=> !rsp_chan.valid)

endmodule

>>> rtl/brip_line_store.sv
// Two one-bit line stores held as one memory of two-bit words, one read and one write port.
// Depends on brip_pkg; the read data is registered.
module brip_line_store (
   input  logic                    clock,
   input  logic                    write_enable,
   input  brip_pkg::coord_type     write_addr,
   input  brip_pkg::line_word_type write_data,
   input  logic                    read_enable,
   input  brip_pkg::coord_type     read_addr,
   output brip_pkg::line_word_type read_data
);

   brip_pkg::line_word_type mem_ff [brip_pkg::MAX_WIDTH];
   brip_pkg::line_word_type read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> rtl/brip_window_cell.sv
// One column cell of the 3x3 window; cells are chained and shift one column per item.
// Depends on brip_pkg.
module brip_window_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  brip_pkg::column_type col_in,
   output brip_pkg::column_type col_out
);

   brip_pkg::column_type col_ff;
   brip_pkg::column_type col_next_in;

   always_comb begin
      col_next_in = shift ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_next_in;
      end
   end

   assign col_out = col_ff;

endmodule
